FILE: rtl/usbcep_pkg.sv
// Shared types and constants for the endpoint-zero control transfer engine.
package usbcep_pkg;

   localparam int PACKET_SIZE = 64;
   localparam int MAX_STRINGS = 4;
   localparam int STRING_REGS = 4;

   localparam logic [1:0] KIND_SETUP   = 2'd0;
   localparam logic [1:0] KIND_OUT     = 2'd1;
   localparam logic [1:0] KIND_IN_DONE = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [15:0] RQ_SET_ADDRESS       = 16'h0005;
   localparam logic [15:0] RQ_GET_DESCRIPTOR    = 16'h8006;
   localparam logic [15:0] RQ_SET_CONFIGURATION = 16'h0009;
   localparam logic [15:0] RQ_SET_INTERFACE     = 16'h010B;
   localparam logic [15:0] LANG_EN_US           = 16'h0409;

   localparam logic [7:0] DESC_DEVICE        = 8'd1;
   localparam logic [7:0] DESC_CONFIGURATION = 8'd2;
   localparam logic [7:0] DESC_STRING        = 8'd3;

   localparam logic [2:0] SRC_NONE          = 3'd0;
   localparam logic [2:0] SRC_DEVICE        = 3'd1;
   localparam logic [2:0] SRC_CONFIGURATION = 3'd2;
   localparam logic [2:0] SRC_STRING_BASE   = 3'd3;

   localparam logic [2:0] CSR_DEVICE_DESC_LEN = 3'd0;
   localparam logic [2:0] CSR_CONF_DESC_LEN   = 3'd1;
   localparam logic [2:0] CSR_STRING_COUNT    = 3'd2;
   localparam logic [2:0] CSR_STRING_LEN_0    = 3'd3;
   localparam logic [2:0] CSR_STRING_LEN_1    = 3'd4;
   localparam logic [2:0] CSR_STRING_LEN_2    = 3'd5;
   localparam logic [2:0] CSR_STRING_LEN_3    = 3'd6;

   typedef enum logic [1:0] {
      ACT_NONE       = 2'd0,
      ACT_STALL      = 2'd1,
      ACT_SEND       = 2'd2,
      ACT_ARM_STATUS = 2'd3
   } usbcep_action_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] request_code;
      logic [15:0] setup_value;
      logic [15:0] setup_index;
      logic [15:0] setup_length;
      logic [6:0]  out_count;
   } usbcep_req_type;

   typedef struct packed {
      usbcep_action_type action;
      logic              setup_handled;
      logic [2:0]        packet_source;
      logic [15:0]       packet_offset;
      logic [6:0]        packet_length;
      logic              address_write;
      logic [6:0]        address_value;
      logic              configuration_write;
      logic [7:0]        configuration_value;
   } usbcep_rsp_type;

   typedef struct packed {
      logic [7:0]                        device_desc_len;
      logic [15:0]                       conf_desc_len;
      logic [2:0]                        string_count;
      logic [STRING_REGS-1:0][7:0]       string_len;
   } usbcep_cfg_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  source;
      logic [15:0] length;
   } usbcep_desc_type;

endpackage

FILE: rtl/usb_control_endpoint_stages.sv
// Top level of the endpoint-zero control transfer engine.
//
// Requests enter on the req_ channel (valid/stall); each one is a setup packet, an OUT
// packet arrival or an IN packet completion. Every accepted request produces exactly one
// result on the rsp_ channel, in order: the action to take (nothing, stall the endpoint,
// send a packet, arm the OUT status stage) plus address or configuration updates and,
// for data packets, the descriptor source, byte offset and length of the packet.
// Descriptor bytes live outside; the host side of the design fetches them from the
// named source and offset.
//
// The request is captured in an input register, decoded against the transfer state, and
// the result lands in the output register once that register is free or being emptied.
// One request is accepted per cycle while the receiver does not stall; the rate is set
// by the single decode step between the two registers, which also updates the state.
// When the receiver stalls, the result register holds and the input register fills;
// only then does req_stall rise.
//
// Reset (synchronous, active high) returns the transfer to idle, empties both registers
// and loads the descriptor length registers with their defaults. The csr_ port writes
// those registers; the user must use it only while no request is in flight (not enforced).
module usb_control_endpoint_stages (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  usbcep_pkg::usbcep_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output usbcep_pkg::usbcep_rsp_type rsp_data,
   input  logic                       csr_write,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_data
);
   import usbcep_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DATA_IN,
      ST_STATUS_OUT,
      ST_STATUS_IN
   } stage_type;

   // Configuration registers.
   usbcep_cfg_type cfg_ff;

   // Input register.
   logic           in_valid_ff;
   usbcep_req_type in_data_ff;

   // Transfer state.
   stage_type   stage_ff, stage_in;
   logic        more_data_ff, more_data_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] next_offset_ff, next_offset_in;
   logic [2:0]  cur_source_ff, cur_source_in;

   // Result register.
   logic           rsp_valid_ff;
   usbcep_rsp_type rsp_data_ff, rsp_data_in;

   usbcep_desc_type desc;
   logic            advance;
   logic            handled;
   logic [15:0]     chunk_base;
   logic            chunk_short;
   logic [6:0]      chunk_len;

   usbcep_desc_sel u_desc_sel (
      .cfg          (cfg_ff),
      .setup_value  (in_data_ff.setup_value),
      .setup_index  (in_data_ff.setup_index),
      .setup_length (in_data_ff.setup_length),
      .desc         (desc)
   );

   // The held request moves on whenever the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Packet splitting: a new descriptor starts from its clipped length, a later IN
   // completion continues from what is left. A short remainder ends the data stage;
   // a full packet leaves the remainder for the next IN, which may be zero bytes long.
   assign chunk_base  = (in_data_ff.req_type == KIND_SETUP) ? desc.length : bytes_left_ff;
   assign chunk_short = chunk_base < 16'(PACKET_SIZE);
   assign chunk_len   = chunk_short ? chunk_base[6:0] : 7'(PACKET_SIZE);

   always_comb begin
      rsp_data_in    = '0;
      rsp_data_in.action = ACT_NONE;
      stage_in       = stage_ff;
      more_data_in   = more_data_ff;
      bytes_left_in  = bytes_left_ff;
      next_offset_in = next_offset_ff;
      cur_source_in  = cur_source_ff;
      handled        = 1'b0;

      unique case (in_data_ff.req_type)
         KIND_SETUP: begin
            // A new setup always replaces whatever transfer was in progress.
            priority if (in_data_ff.request_code == RQ_SET_ADDRESS) begin
               if (in_data_ff.setup_index == 16'd0 && in_data_ff.setup_length == 16'd0) begin
                  handled                   = 1'b1;
                  rsp_data_in.address_write = 1'b1;
                  rsp_data_in.address_value = in_data_ff.setup_value[6:0];
               end
            end else if (in_data_ff.request_code == RQ_GET_DESCRIPTOR) begin
               if (desc.hit) begin
                  handled                   = 1'b1;
                  rsp_data_in.packet_source = desc.source;
                  rsp_data_in.packet_length = chunk_len;
                  cur_source_in             = desc.source;
               end
            end else if (in_data_ff.request_code == RQ_SET_CONFIGURATION) begin
               if (in_data_ff.setup_index == 16'd0 && in_data_ff.setup_length == 16'd0) begin
                  handled                         = 1'b1;
                  rsp_data_in.configuration_write = 1'b1;
                  rsp_data_in.configuration_value = in_data_ff.setup_value[7:0];
               end
            end else if (in_data_ff.request_code == RQ_SET_INTERFACE) begin
               if (in_data_ff.setup_length == 16'd0) begin
                  handled = 1'b1;
               end
            end else begin
               // Any other request stays unhandled and is refused below.
            end

            if (!handled) begin
               rsp_data_in.action = ACT_STALL;
               stage_in           = ST_IDLE;
            end else if (in_data_ff.request_code == RQ_GET_DESCRIPTOR) begin
               rsp_data_in.action        = ACT_SEND;
               rsp_data_in.setup_handled = 1'b1;
               stage_in                  = ST_DATA_IN;
               if (chunk_short) begin
                  more_data_in   = 1'b0;
                  next_offset_in = 16'd0;
                  bytes_left_in  = chunk_base;
               end else begin
                  more_data_in   = 1'b1;
                  next_offset_in = 16'(PACKET_SIZE);
                  bytes_left_in  = chunk_base - 16'(PACKET_SIZE);
               end
            end else begin
               // Requests without a data stage answer with a zero-length status packet.
               rsp_data_in.action        = ACT_SEND;
               rsp_data_in.setup_handled = 1'b1;
               more_data_in              = 1'b0;
               stage_in                  = ST_STATUS_IN;
            end
         end

         KIND_OUT: begin
            // Only the zero-length status packet is expected; anything else is an error.
            if (!(stage_ff == ST_STATUS_OUT && in_data_ff.out_count == 7'd0)) begin
               rsp_data_in.action = ACT_STALL;
            end
            stage_in = ST_IDLE;
         end

         KIND_IN_DONE: begin
            priority if (stage_ff == ST_DATA_IN) begin
               if (more_data_ff) begin
                  rsp_data_in.action        = ACT_SEND;
                  rsp_data_in.packet_source = cur_source_ff;
                  rsp_data_in.packet_offset = next_offset_ff;
                  rsp_data_in.packet_length = chunk_len;
                  if (chunk_short) begin
                     more_data_in = 1'b0;
                  end else begin
                     next_offset_in = next_offset_ff + 16'(PACKET_SIZE);
                     bytes_left_in  = bytes_left_ff - 16'(PACKET_SIZE);
                  end
               end else begin
                  rsp_data_in.action = ACT_ARM_STATUS;
                  stage_in           = ST_STATUS_OUT;
               end
            end else if (stage_ff == ST_STATUS_IN) begin
               stage_in = ST_IDLE;
            end else begin
               rsp_data_in.action = ACT_STALL;
               stage_in           = ST_IDLE;
            end
         end

         KIND_UNUSED: begin
            // Ignored: an empty result and no change of state.
         end

         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_desc_len <= 8'd18;
         cfg_ff.conf_desc_len   <= 16'd0;
         cfg_ff.string_count    <= 3'd1;
         cfg_ff.string_len[0]   <= 8'd4;
         cfg_ff.string_len[1]   <= 8'd0;
         cfg_ff.string_len[2]   <= 8'd0;
         cfg_ff.string_len[3]   <= 8'd0;
         in_valid_ff            <= 1'b0;
         stage_ff               <= ST_IDLE;
         more_data_ff           <= 1'b0;
         bytes_left_ff          <= 16'd0;
         next_offset_ff         <= 16'd0;
         cur_source_ff          <= SRC_NONE;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DEVICE_DESC_LEN: cfg_ff.device_desc_len <= csr_data[7:0];
               CSR_CONF_DESC_LEN:   cfg_ff.conf_desc_len   <= csr_data;
               CSR_STRING_COUNT:    cfg_ff.string_count    <= csr_data[2:0];
               CSR_STRING_LEN_0:    cfg_ff.string_len[0]   <= csr_data[7:0];
               CSR_STRING_LEN_1:    cfg_ff.string_len[1]   <= csr_data[7:0];
               CSR_STRING_LEN_2:    cfg_ff.string_len[2]   <= csr_data[7:0];
               CSR_STRING_LEN_3:    cfg_ff.string_len[3]   <= csr_data[7:0];
               default: begin
               end
            endcase
         end

         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end

         if (advance) begin
            stage_ff       <= stage_in;
            more_data_ff   <= more_data_in;
            bytes_left_ff  <= bytes_left_in;
            next_offset_ff <= next_offset_in;
            cur_source_ff  <= cur_source_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Payload registers carry no reset.
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The input side only backs up when the result register is full and held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // A decoded request always shows up as a result in the next cycle.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("decoded request produced no result");

   // A data packet never exceeds the endpoint packet size.
   a_packet_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.packet_length <= 7'(PACKET_SIZE)))
      else $error("packet length above packet size");

   // Every handled setup request answers with a packet to send.
   a_handled_sends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.setup_handled) |-> (rsp_data.action == ACT_SEND))
      else $error("handled setup without a packet");

endmodule

FILE: rtl/usbcep_desc_sel.sv
// Descriptor lookup for GET_DESCRIPTOR: picks the source and its length, clipped to wLength.
module usbcep_desc_sel (
   input  usbcep_pkg::usbcep_cfg_type  cfg,
   input  logic [15:0]                 setup_value,
   input  logic [15:0]                 setup_index,
   input  logic [15:0]                 setup_length,
   output usbcep_pkg::usbcep_desc_type desc
);
   import usbcep_pkg::*;

   logic [7:0]  desc_kind;
   logic [7:0]  desc_idx;
   logic        string_ok;
   logic [15:0] full_len;

   assign desc_kind = setup_value[15:8];
   assign desc_idx  = setup_value[7:0];

   // A nonzero string index must exist and must be asked for in US English.
   assign string_ok = (desc_idx != 8'd0) && (desc_idx < {5'd0, cfg.string_count})
                      && (desc_idx < 8'(MAX_STRINGS)) && (setup_index == LANG_EN_US);

   always_comb begin
      desc.hit    = 1'b0;
      desc.source = SRC_NONE;
      full_len    = 16'd0;
      priority if (desc_kind == DESC_DEVICE) begin
         if (desc_idx == 8'd0 || setup_index == 16'd0) begin
            desc.hit    = 1'b1;
            desc.source = SRC_DEVICE;
            full_len    = {8'd0, cfg.device_desc_len};
         end
      end else if (desc_kind == DESC_CONFIGURATION) begin
         if (desc_idx == 8'd0 || setup_index == 16'd0) begin
            desc.hit    = 1'b1;
            desc.source = SRC_CONFIGURATION;
            full_len    = cfg.conf_desc_len;
         end
      end else if (desc_kind == DESC_STRING) begin
         if (desc_idx == 8'd0 && setup_index == 16'd0) begin
            desc.hit    = 1'b1;
            desc.source = SRC_STRING_BASE;
            full_len    = {8'd0, cfg.string_len[0]};
         end else if (string_ok) begin
            desc.hit    = 1'b1;
            desc.source = SRC_STRING_BASE + {1'b0, desc_idx[1:0]};
            full_len    = {8'd0, cfg.string_len[desc_idx[1:0]]};
         end
      end else begin
         // Other descriptor types are not served.
      end
      desc.length = (setup_length < full_len) ? setup_length : full_len;
   end

endmodule
